[rtl/core/pce_pkg.sv]
// Shared types, constants and fixed-point helpers for the pendulum chain energy block.
// Used by pce_mul, pce_ctrl, pce_dp and the top level; depends on nothing else.
package pce_pkg;

    localparam int SUM_W   = 48;
    localparam int MAG_W   = 63;
    localparam int MB_W    = 34;
    localparam int SH_W    = 5;
    localparam int IN_W    = 112;
    localparam int OUT_W   = 192;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 32;

    localparam logic [63:0] ONE_Q30        = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [63:0] PI_Q30         = 64'd3373259426;
    localparam logic [63:0] TWO_PI_Q30     = 64'd6746518852;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [48:0] TERM_CAP       = 49'h1_0000_0000_0000;

    localparam logic [CIDX_W-1:0] CFG_INV_DT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RING   = 2'd2;

    localparam logic [1:0] MODE_GRAV = 2'd0;
    localparam logic [1:0] MODE_HARM = 2'd1;

    localparam logic [SH_W-1:0] SH_NONE   = 5'd0;
    localparam logic [SH_W-1:0] SH_Q8     = 5'd8;
    localparam logic [SH_W-1:0] SH_Q16    = 5'd16;
    localparam logic [SH_W-1:0] SH_HALF16 = 5'd17;
    localparam logic [SH_W-1:0] SH_Q24    = 5'd24;
    localparam logic [SH_W-1:0] SH_Q30    = 5'd30;

    typedef enum logic [4:0] {
        OP_C_SQ, OP_C_ML, OP_C_L, OP_C_K, OP_C_D, OP_C_I,
        OP_K_SQ, OP_K_ML, OP_K_L, OP_K_D, OP_K_I,
        OP_P_G, OP_P_FR, OP_P_POS, OP_P_IP, OP_P_C, OP_P_I0,
        OP_P_SQ, OP_P_D, OP_P_I1
    } op_t;

    typedef struct packed {
        logic load;
        logic start;
        op_t  op;
        logic ring_sel;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic       done;
        logic       have_prev;
        logic       last;
        logic       ring;
        logic [1:0] mode;
        logic       out_free;
    } sts_t;

    // Taylor series of cos up to x^18, Q2.30, for 0 <= x <= pi/2.
    function automatic logic signed [63:0] cos_q30(logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        localparam logic [63:0] HALF = 64'd536870912;
        x2   = (x * x + HALF) >> 30;
        term = ONE_Q30;
        acc  = $signed(ONE_Q30);
        term = ((term * x2 + HALF) >> 30) / 64'd2;   acc = acc - $signed(term);
        term = ((term * x2 + HALF) >> 30) / 64'd12;  acc = acc + $signed(term);
        term = ((term * x2 + HALF) >> 30) / 64'd30;  acc = acc - $signed(term);
        term = ((term * x2 + HALF) >> 30) / 64'd56;  acc = acc + $signed(term);
        term = ((term * x2 + HALF) >> 30) / 64'd90;  acc = acc - $signed(term);
        term = ((term * x2 + HALF) >> 30) / 64'd132; acc = acc + $signed(term);
        term = ((term * x2 + HALF) >> 30) / 64'd182; acc = acc - $signed(term);
        term = ((term * x2 + HALF) >> 30) / 64'd240; acc = acc + $signed(term);
        term = ((term * x2 + HALF) >> 30) / 64'd306; acc = acc - $signed(term);
        return acc;
    endfunction

    // One table entry of 1 - cos(theta), Q2.30, theta in [0, 2*pi).
    function automatic logic [31:0] omc_value(logic [63:0] th);
        logic [63:0]        t;
        logic signed [63:0] v;
        t = th;
        if (t > PI_Q30) t = TWO_PI_Q30 - t;
        if (t <= HALF_PI_Q30) v = $signed(ONE_Q30) - cos_q30(t);
        else v = $signed(ONE_Q30) + cos_q30(PI_Q30 - t);
        if (v < 0) v = 0;
        if (v > $signed(2 * ONE_Q30)) v = $signed(2 * ONE_Q30);
        return v[31:0];
    endfunction

    // Magnitude capped at 2^48, then given its sign.
    function automatic logic signed [49:0] term_of(logic [MAG_W-1:0] mag, logic neg);
        logic [48:0] m;
        m = (mag > MAG_W'(TERM_CAP)) ? TERM_CAP : mag[48:0];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                        logic signed [49:0] b);
        logic signed [50:0] s;
        s = 51'(a) + 51'(b);
        if (s[50:47] == 4'b0000 || s[50:47] == 4'b1111) return s[47:0];
        return s[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    endfunction

endpackage

[rtl/core/pce_mul.sv]
// Multi-cycle unsigned multiply with rounding shift and saturation at 2^62.
// Splits the 63-bit operand into 32/31-bit halves for two partial products; uses pce_pkg.
module pce_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pce_pkg::MAG_W-1:0]   a,
    input  logic [pce_pkg::MB_W-1:0]    b,
    input  logic [pce_pkg::SH_W-1:0]    sh,
    output logic                        done,
    output logic [pce_pkg::MAG_W-1:0]   res
);

    logic [pce_pkg::MAG_W-1:0] a_reg;
    logic [pce_pkg::MB_W-1:0]  b_reg;
    logic [pce_pkg::SH_W-1:0]  sh_reg;
    logic [1:0]                step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [65:0]               plo_reg;
    logic [64:0]               phi_reg;
    logic [97:0]               full_reg;
    logic [pce_pkg::MAG_W-1:0] res_reg;
    logic [97:0]               half;
    logic [97:0]               shifted;
    logic                      over;

    assign half    = (sh_reg == pce_pkg::SH_NONE) ? 98'd0 : (98'd1 << (sh_reg - 5'd1));
    assign shifted = full_reg >> sh_reg;
    assign over    = (shifted[97:63] != '0) || (shifted[62] && (shifted[61:0] != '0));

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            a_reg  <= a;
            b_reg  <= b;
            sh_reg <= sh;
        end
        if (busy_reg) begin
            unique case (step_reg)
                2'd0: plo_reg <= 66'(a_reg[31:0]) * 66'(b_reg);
                2'd1: phi_reg <= 65'(a_reg[62:32]) * 65'(b_reg);
                2'd2: full_reg <= {1'b0, phi_reg, 32'd0} + 98'(plo_reg) + half;
                2'd3: res_reg <= over ? {1'b1, 62'd0} : shifted[62:0];
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

[rtl/core/pce_ctrl.sv]
// Controller state machine: sequences the products of one pendulum item.
// Talks to pce_dp only through pce_pkg::cmd_t and pce_pkg::sts_t.
module pce_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pce_pkg::sts_t  sts,
    output pce_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    pce_pkg::op_t   op_reg, op_next;
    logic           ring_reg, ring_next;
    logic           go_tail;
    logic           has_pot;

    assign has_pot = (sts.mode == pce_pkg::MODE_GRAV) || (sts.mode == pce_pkg::MODE_HARM);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        ring_next    = ring_reg;
        go_tail      = 1'b0;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.ring_sel = ring_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    ring_next  = 1'b0;
                    op_next    = sts.have_prev ? pce_pkg::OP_C_SQ : pce_pkg::OP_K_SQ;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.done) begin
                    state_next = ST_ISSUE;
                    unique case (op_reg)
                        pce_pkg::OP_C_SQ:  op_next = pce_pkg::OP_C_ML;
                        pce_pkg::OP_C_ML:  op_next = pce_pkg::OP_C_L;
                        pce_pkg::OP_C_L:   op_next = pce_pkg::OP_C_K;
                        pce_pkg::OP_C_K:   op_next = pce_pkg::OP_C_D;
                        pce_pkg::OP_C_D:   op_next = pce_pkg::OP_C_I;
                        pce_pkg::OP_C_I: begin
                            if (ring_reg) state_next = ST_EMIT;
                            else op_next = pce_pkg::OP_K_SQ;
                        end
                        pce_pkg::OP_K_SQ:  op_next = pce_pkg::OP_K_ML;
                        pce_pkg::OP_K_ML:  op_next = pce_pkg::OP_K_L;
                        pce_pkg::OP_K_L:   op_next = pce_pkg::OP_K_D;
                        pce_pkg::OP_K_D:   op_next = pce_pkg::OP_K_I;
                        pce_pkg::OP_K_I: begin
                            if (has_pot) op_next = pce_pkg::OP_P_G;
                            else go_tail = 1'b1;
                        end
                        pce_pkg::OP_P_G:
                            op_next = (sts.mode == pce_pkg::MODE_GRAV) ?
                                      pce_pkg::OP_P_FR : pce_pkg::OP_P_SQ;
                        pce_pkg::OP_P_FR:  op_next = pce_pkg::OP_P_POS;
                        pce_pkg::OP_P_POS: op_next = pce_pkg::OP_P_IP;
                        pce_pkg::OP_P_IP:  op_next = pce_pkg::OP_P_C;
                        pce_pkg::OP_P_C:   op_next = pce_pkg::OP_P_I0;
                        pce_pkg::OP_P_SQ:  op_next = pce_pkg::OP_P_D;
                        pce_pkg::OP_P_D:   op_next = pce_pkg::OP_P_I1;
                        pce_pkg::OP_P_I0,
                        pce_pkg::OP_P_I1:  go_tail = 1'b1;
                        default:           go_tail = 1'b1;
                    endcase
                    // End of the item: the closing ring pair reruns the coupling products.
                    if (go_tail) begin
                        if (!sts.last) begin
                            state_next = ST_IDLE;
                        end else if (sts.ring) begin
                            op_next   = pce_pkg::OP_C_SQ;
                            ring_next = 1'b1;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= pce_pkg::OP_K_SQ;
            ring_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ring_reg  <= ring_next;
        end
    end

endmodule

[rtl/core/pce_dp.sv]
// Datapath: item and neighbor registers, running sums, 1-cos table, result register.
// Instantiates pce_mul; driven by pce_ctrl commands; uses pce_pkg.
module pce_dp #(
    parameter int MAX_PENDULUMS   = 1024,
    parameter int COS_TABLE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pce_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tlast,
    output logic [pce_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    input  logic [pce_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [pce_pkg::CDATA_W-1:0]   cfg_data,
    input  pce_pkg::cmd_t                 cmd,
    output pce_pkg::sts_t                 sts
);

    localparam int CNT_W = $clog2(MAX_PENDULUMS);
    localparam int IDX_W = $clog2(COS_TABLE_DEPTH);

    // Table of 1 - cos over one turn, Q2.30.
    logic [31:0] cos_tab [COS_TABLE_DEPTH];
    for (genvar p = 0; p < COS_TABLE_DEPTH; p++) begin : g_tab
        localparam logic [63:0] TH = (pce_pkg::TWO_PI_Q30 * 64'(p) +
                                      64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
        localparam logic [31:0] OMC = pce_pkg::omc_value(TH);
        assign cos_tab[p] = OMC;
    end

    logic [31:0] inv_dt_reg;
    logic [1:0]  mode_reg;
    logic        ring_reg;

    logic signed [15:0] cur_angle, cur_before, cur_g, cur_k, cur_phase;
    logic [15:0]        cur_mass, cur_len;
    logic               last_reg;
    logic signed [15:0] hp_angle, hp_k, hp_phase, first_angle;
    logic [15:0]        hp_mass, hp_len;
    logic               have_prev_reg;
    logic [CNT_W-1:0]   count_reg;

    logic signed [pce_pkg::SUM_W-1:0] kin_reg, cpl_reg, pot_reg;
    logic [33:0] sq_reg;
    logic [31:0] ml_reg;
    logic [62:0] t_reg;
    logic [43:0] frac_reg;
    logic [55:0] pos_reg;
    logic [31:0] omc_reg;
    pce_pkg::op_t op_q;

    logic                     out_valid_reg;
    logic [pce_pkg::OUT_W-1:0] out_data_reg;

    logic                      mul_done;
    logic [pce_pkg::MAG_W-1:0] mul_res, mul_a;
    logic [pce_pkg::MB_W-1:0]  mul_b;
    logic [pce_pkg::SH_W-1:0]  mul_sh;

    logic signed [15:0] partner;
    logic signed [17:0] cd;
    logic [16:0]        ad;
    logic signed [16:0] dv, ang17, g17, k17;
    logic [15:0]        adv, aang, ag, ak;
    logic [IDX_W-1:0]   idx, nxt;
    logic [31:0]        a0, a1, diff;
    logic               out_free;
    logic signed [pce_pkg::SUM_W-1:0] kc_sum, e_sum;

    assign partner = cmd.ring_sel ? first_angle : cur_angle;
    assign cd      = 18'(hp_angle) - 18'(partner) + 18'(hp_phase);
    assign ad      = cd[17] ? 17'(-cd) : 17'(cd);
    assign dv      = 17'(cur_angle) - 17'(cur_before);
    assign adv     = dv[16] ? 16'(-dv) : 16'(dv);
    assign ang17   = 17'(cur_angle);
    assign aang    = ang17[16] ? 16'(-ang17) : 16'(ang17);
    assign g17     = 17'(cur_g);
    assign ag      = g17[16] ? 16'(-g17) : 16'(g17);
    assign k17     = 17'(hp_k);
    assign ak      = k17[16] ? 16'(-k17) : 16'(k17);

    assign idx  = pos_reg[44 +: IDX_W];
    assign nxt  = (idx == IDX_W'(COS_TABLE_DEPTH - 1)) ? '0 : idx + 1'b1;
    assign a0   = cos_tab[idx];
    assign a1   = cos_tab[nxt];
    assign diff = (a1 >= a0) ? a1 - a0 : a0 - a1;

    always_comb begin
        mul_a  = t_reg;
        mul_b  = 34'(inv_dt_reg);
        mul_sh = pce_pkg::SH_HALF16;
        unique case (cmd.op)
            pce_pkg::OP_C_SQ:  begin mul_a = 63'(ad); mul_b = 34'(ad); mul_sh = pce_pkg::SH_NONE; end
            pce_pkg::OP_C_ML:  begin
                mul_a = 63'(hp_mass); mul_b = 34'(hp_len); mul_sh = pce_pkg::SH_NONE;
            end
            pce_pkg::OP_C_L:   begin mul_b = 34'(hp_len); mul_sh = pce_pkg::SH_Q8; end
            pce_pkg::OP_C_K:   begin mul_b = 34'(ak); mul_sh = pce_pkg::SH_Q8; end
            pce_pkg::OP_C_D,
            pce_pkg::OP_K_D,
            pce_pkg::OP_P_D:   begin mul_b = sq_reg; mul_sh = pce_pkg::SH_Q24; end
            pce_pkg::OP_C_I,
            pce_pkg::OP_K_I,
            pce_pkg::OP_P_I1:  ;
            pce_pkg::OP_K_SQ:  begin mul_a = 63'(adv); mul_b = 34'(adv); mul_sh = pce_pkg::SH_NONE; end
            pce_pkg::OP_K_ML:  begin
                mul_a = 63'(cur_mass); mul_b = 34'(cur_len); mul_sh = pce_pkg::SH_NONE;
            end
            pce_pkg::OP_K_L:   begin mul_a = 63'(ml_reg); mul_b = 34'(cur_len); mul_sh = pce_pkg::SH_Q8; end
            pce_pkg::OP_P_G:   begin mul_a = 63'(ml_reg); mul_b = 34'(ag); mul_sh = pce_pkg::SH_Q8; end
            pce_pkg::OP_P_FR:  begin
                mul_a = 63'(aang); mul_b = 34'(pce_pkg::INV_TWO_PI_Q32); mul_sh = pce_pkg::SH_NONE;
            end
            pce_pkg::OP_P_POS: begin
                mul_a = 63'(frac_reg); mul_b = 34'(COS_TABLE_DEPTH); mul_sh = pce_pkg::SH_NONE;
            end
            pce_pkg::OP_P_IP:  begin mul_a = 63'(diff); mul_b = 34'(pos_reg[43:28]); mul_sh = pce_pkg::SH_Q16; end
            pce_pkg::OP_P_C:   begin mul_b = 34'(omc_reg); mul_sh = pce_pkg::SH_Q30; end
            pce_pkg::OP_P_I0:  mul_sh = pce_pkg::SH_Q16;
            pce_pkg::OP_P_SQ:  begin mul_a = 63'(aang); mul_b = 34'(aang); mul_sh = pce_pkg::SH_NONE; end
            default: ;
        endcase
    end

    pce_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .a       (mul_a),
        .b       (mul_b),
        .sh      (mul_sh),
        .done    (mul_done),
        .res     (mul_res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign kc_sum   = pce_pkg::sat_add(kin_reg, 50'(cpl_reg));
    assign e_sum    = pce_pkg::sat_add(kc_sum, 50'(pot_reg));

    // Control state and running sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_dt_reg    <= 32'd65536;
            mode_reg      <= pce_pkg::MODE_GRAV;
            ring_reg      <= 1'b1;
            kin_reg       <= '0;
            cpl_reg       <= '0;
            pot_reg       <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    pce_pkg::CFG_INV_DT: inv_dt_reg <= cfg_data;
                    pce_pkg::CFG_MODE:   mode_reg   <= cfg_data[1:0];
                    pce_pkg::CFG_RING:   ring_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tready && !(cmd.emit && out_free)) out_valid_reg <= 1'b0;
            if (mul_done) begin
                unique case (op_q)
                    pce_pkg::OP_C_I:
                        cpl_reg <= pce_pkg::sat_add(cpl_reg,
                                   pce_pkg::term_of(mul_res, !hp_k[15] && (hp_k != '0)));
                    pce_pkg::OP_K_I: begin
                        kin_reg       <= pce_pkg::sat_add(kin_reg, pce_pkg::term_of(mul_res, 1'b0));
                        have_prev_reg <= 1'b1;
                        count_reg     <= count_reg + 1'b1;
                    end
                    pce_pkg::OP_P_I0,
                    pce_pkg::OP_P_I1:
                        pot_reg <= pce_pkg::sat_add(pot_reg,
                                   pce_pkg::term_of(mul_res, !cur_g[15] && (cur_g != '0)));
                    default: ;
                endcase
            end
            if (cmd.emit && out_free) begin
                out_valid_reg <= 1'b1;
                kin_reg       <= '0;
                cpl_reg       <= '0;
                pot_reg       <= '0;
                have_prev_reg <= 1'b0;
                count_reg     <= '0;
            end
        end
    end

    // Payload, product and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_angle  <= s_tdata[15:0];
            cur_before <= s_tdata[31:16];
            cur_mass   <= s_tdata[47:32];
            cur_len    <= s_tdata[63:48];
            cur_g      <= s_tdata[79:64];
            cur_k      <= s_tdata[95:80];
            cur_phase  <= s_tdata[111:96];
            last_reg   <= s_tlast || (count_reg == CNT_W'(MAX_PENDULUMS - 1));
            if (!have_prev_reg) first_angle <= s_tdata[15:0];
        end
        if (cmd.start) op_q <= cmd.op;
        if (mul_done) begin
            unique case (op_q)
                pce_pkg::OP_C_SQ,
                pce_pkg::OP_K_SQ,
                pce_pkg::OP_P_SQ:  sq_reg   <= mul_res[33:0];
                pce_pkg::OP_K_ML:  ml_reg   <= mul_res[31:0];
                pce_pkg::OP_P_FR:  frac_reg <= mul_res[43:0];
                pce_pkg::OP_P_POS: pos_reg  <= mul_res[55:0];
                pce_pkg::OP_P_IP:
                    omc_reg <= (a1 >= a0) ? a0 + mul_res[31:0] : a0 - mul_res[31:0];
                pce_pkg::OP_K_I: begin
                    hp_angle <= cur_angle;
                    hp_mass  <= cur_mass;
                    hp_len   <= cur_len;
                    hp_k     <= cur_k;
                    hp_phase <= cur_phase;
                end
                pce_pkg::OP_C_I,
                pce_pkg::OP_P_I0,
                pce_pkg::OP_P_I1:  ;
                default:           t_reg <= mul_res;
            endcase
        end
        if (cmd.emit && out_free)
            out_data_reg <= {e_sum, pot_reg, cpl_reg, kin_reg};
    end

    assign sts.done      = mul_done;
    assign sts.have_prev = have_prev_reg;
    assign sts.last      = last_reg;
    assign sts.ring      = ring_reg;
    assign sts.mode      = mode_reg;
    assign sts.out_free  = out_free;

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

endmodule

[rtl/core/pendulum_chain_energy_totals_top.sv]
// Pendulum chain energy totals: one shared multi-cycle multiplier does every product.
// Each product runs issue, the multiplier's four steps (two partial products, rounded
// sum, shift and saturate) and done; an item needs 5 to 23 products, set by neighbor,
// potential mode and the closing ring pair; the last item of a chain waits to emit while the
// result register is still held. One item at a time; totals leave through a result register.
// Reset (aresetn low, synchronous) clears sums and handshakes and restores the registers.
module pendulum_chain_energy_totals_top #(
    parameter int MAX_PENDULUMS   = 1024,
    parameter int COS_TABLE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // angle_now, angle_before, mass, arm_length, gravity_coef, coupling_coef, phase_offset
    input  logic [pce_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // kinetic_total, coupling_total, potential_total, energy_total
    output logic [pce_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pce_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [pce_pkg::CDATA_W-1:0]   cfg_data
);

    pce_pkg::cmd_t cmd;
    pce_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pce_dp #(
        .MAX_PENDULUMS   (MAX_PENDULUMS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_emit_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && sts.out_free |=> m_tvalid)
        else $error("totals not presented after emit");

    a_no_start_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> !cmd.start)
        else $error("multiplier started while a product completes");

endmodule

[tb/pce_energy_checker.sv]
// Checker for the pendulum chain energy block: follows the configuration and input
// beats, predicts the chain totals in fixed point and compares every result beat.
// Depends on pce_pkg for the register indexes, the mode codes and the port widths.
module pce_energy_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pce_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [pce_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pce_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [pce_pkg::CDATA_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            totals_waiting
);
    import pce_pkg::*;

    localparam int          CHAIN_MAX  = 1024;
    localparam int          OMC_DEPTH  = 256;
    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [63:0] Q30_HPI    = 64'd1686629713;
    localparam logic [63:0] Q30_PI     = 64'd3373259426;
    localparam logic [63:0] Q30_TWO_PI = 64'd6746518852;
    localparam logic [63:0] TURN_RECIP = 64'd683565276;
    localparam logic [63:0] PROD_CAP   = 64'h4000_0000_0000_0000;
    localparam longint      MAG_CAP    = 64'sd281474976710656;
    localparam longint      TOTAL_MAX  = 64'sd140737488355327;
    localparam longint      TOTAL_MIN  = -64'sd140737488355328;

    typedef struct {
        longint kinetic;
        longint coupling;
        longint potential;
        longint energy;
    } chain_totals_t;

    typedef struct {
        int          angle;
        logic [63:0] mass;
        logic [63:0] length;
        int          coupling;
        int          phase;
    } pendulum_t;

    logic [63:0]   omc_lut [OMC_DEPTH];
    chain_totals_t totals_q[$];

    logic [31:0] inv_dt_sq;
    logic [1:0]  pot_mode;
    logic        ring_on;
    longint      kin_acc, cpl_acc, pot_acc;
    pendulum_t   prev_pend;
    int          first_ang;
    bit          have_prev;
    int          chain_len;

    function automatic logic [63:0] cos_series(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x2   = (x * x + (Q30_ONE >> 1)) >> 30;
        term = Q30_ONE;
        acc  = longint'(Q30_ONE);
        for (int k = 1; k <= 9; k++) begin
            term = ((term * x2 + (Q30_ONE >> 1)) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return 64'(acc);
    endfunction

    // Rounded, shifted product of two magnitudes, capped at 2^62.
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (sh > 0) p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        return (p > {64'd0, PROD_CAP}) ? PROD_CAP : p[63:0];
    endfunction

    function automatic longint signed_mag(logic [63:0] mag, bit neg);
        longint m;
        m = (mag > 64'(MAG_CAP)) ? MAG_CAP : longint'(mag);
        return neg ? -m : m;
    endfunction

    function automatic longint clamp_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > TOTAL_MAX) return TOTAL_MAX;
        if (s < TOTAL_MIN) return TOTAL_MIN;
        return s;
    endfunction

    function automatic logic [63:0] abs_of(int v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // 1 - cos of a Q4.12 angle, Q2.30, interpolated between table entries.
    function automatic logic [63:0] versine(int angle);
        logic [63:0] frac, pos, f, a0, a1;
        int          idx, nxt;
        frac = (abs_of(angle) * TURN_RECIP) & ((64'd1 << 44) - 1);
        pos  = frac * OMC_DEPTH;
        idx  = int'(pos >> 44);
        f    = (pos >> 28) & 64'hFFFF;
        if (idx >= OMC_DEPTH) idx = OMC_DEPTH - 1;
        nxt = (idx + 1 >= OMC_DEPTH) ? 0 : idx + 1;
        a0  = omc_lut[idx];
        a1  = omc_lut[nxt];
        if (a1 >= a0) return a0 + (((a1 - a0) * f + 64'd32768) >> 16);
        return a0 - (((a0 - a1) * f + 64'd32768) >> 16);
    endfunction

    function automatic longint pair_coupling(pendulum_t p, int later_angle);
        logic [63:0] d, t;
        d = abs_of(p.angle - later_angle + p.phase);
        t = p.mass * p.length;
        t = scaled_product(t, p.length, 8);
        t = scaled_product(t, abs_of(p.coupling), 8);
        t = scaled_product(t, d * d, 24);
        t = scaled_product(t, 64'(inv_dt_sq), 17);
        return signed_mag(t, p.coupling > 0);
    endfunction

    task automatic add_pendulum(logic [IN_W-1:0] d, logic last_flag);
        pendulum_t     cur;
        int            ang_prev, grav;
        logic [63:0]   ml, t, dv, ag;
        bit            last;
        chain_totals_t tot;
        cur.angle    = int'($signed(d[15:0]));
        ang_prev     = int'($signed(d[31:16]));
        cur.mass     = 64'(d[47:32]);
        cur.length   = 64'(d[63:48]);
        grav         = int'($signed(d[79:64]));
        cur.coupling = int'($signed(d[95:80]));
        cur.phase    = int'($signed(d[111:96]));
        last = last_flag || (chain_len + 1 >= CHAIN_MAX);

        if (!have_prev) first_ang = cur.angle;
        else cpl_acc = clamp_add(cpl_acc, pair_coupling(prev_pend, cur.angle));

        ml = cur.mass * cur.length;
        dv = abs_of(cur.angle - ang_prev);
        t  = scaled_product(ml, cur.length, 8);
        t  = scaled_product(t, dv * dv, 24);
        t  = scaled_product(t, 64'(inv_dt_sq), 17);
        kin_acc = clamp_add(kin_acc, signed_mag(t, 1'b0));

        ag = abs_of(grav);
        if (pot_mode == MODE_GRAV) begin
            t = scaled_product(ml, ag, 8);
            t = scaled_product(t, versine(cur.angle), 30);
            t = scaled_product(t, 64'(inv_dt_sq), 16);
            pot_acc = clamp_add(pot_acc, signed_mag(t, grav > 0));
        end else if (pot_mode == MODE_HARM) begin
            t = scaled_product(ml, ag, 8);
            t = scaled_product(t, abs_of(cur.angle) * abs_of(cur.angle), 24);
            t = scaled_product(t, 64'(inv_dt_sq), 17);
            pot_acc = clamp_add(pot_acc, signed_mag(t, grav > 0));
        end

        prev_pend = cur;
        have_prev = 1'b1;
        chain_len++;
        if (last) begin
            if (ring_on) cpl_acc = clamp_add(cpl_acc, pair_coupling(cur, first_ang));
            tot.kinetic   = kin_acc;
            tot.coupling  = cpl_acc;
            tot.potential = pot_acc;
            tot.energy    = clamp_add(clamp_add(kin_acc, cpl_acc), pot_acc);
            totals_q.push_back(tot);
            kin_acc   = 0;
            cpl_acc   = 0;
            pot_acc   = 0;
            have_prev = 1'b0;
            chain_len = 0;
        end
    endtask

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        logic [63:0] th;
        fail_count     = 0;
        totals_waiting = 0;
        for (int p = 0; p < OMC_DEPTH; p++) begin
            longint v;
            th = (Q30_TWO_PI * 64'(p) + OMC_DEPTH / 2) / OMC_DEPTH;
            if (th > Q30_PI) th = Q30_TWO_PI - th;
            if (th <= Q30_HPI) v = longint'(Q30_ONE) - longint'(cos_series(th));
            else v = longint'(Q30_ONE) + longint'(cos_series(Q30_PI - th));
            if (v < 0) v = 0;
            if (v > 2 * longint'(Q30_ONE)) v = 2 * longint'(Q30_ONE);
            omc_lut[p] = 64'(v);
        end
    end

    always @(posedge aclk) begin
        chain_totals_t want;
        if (!aresetn) begin
            inv_dt_sq = 32'd65536;
            pot_mode  = MODE_GRAV;
            ring_on   = 1'b1;
            kin_acc   = 0;
            cpl_acc   = 0;
            pot_acc   = 0;
            have_prev = 1'b0;
            chain_len = 0;
            totals_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INV_DT: inv_dt_sq = cfg_data;
                    CFG_MODE:   pot_mode  = cfg_data[1:0];
                    CFG_RING:   ring_on   = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (totals_q.size() == 0) begin
                    $display("[%0t] MISMATCH result beat with no chain pending: %h",
                             $realtime, m_tdata);
                    fail_count++;
                end else begin
                    want = totals_q.pop_front();
                    if (m_tdata[47:0] !== want.kinetic[47:0])
                        report_mismatch("kinetic_total", m_tdata[47:0], want.kinetic[47:0]);
                    if (m_tdata[95:48] !== want.coupling[47:0])
                        report_mismatch("coupling_total", m_tdata[95:48], want.coupling[47:0]);
                    if (m_tdata[143:96] !== want.potential[47:0])
                        report_mismatch("potential_total", m_tdata[143:96],
                                        want.potential[47:0]);
                    if (m_tdata[191:144] !== want.energy[47:0])
                        report_mismatch("energy_total", m_tdata[191:144], want.energy[47:0]);
                end
            end
            if (s_tvalid && s_tready) add_pendulum(s_tdata, s_tlast);
        end
        totals_waiting = totals_q.size();
    end

endmodule

[tb/tb_pendulum_chain_energy_totals_top.sv]
// Testbench top for the pendulum chain energy block: clock, reset, configuration,
// directed and random pendulum chains with random idling; verdict from pce_energy_checker.
// Depends on pce_pkg, pendulum_chain_energy_totals_top and pce_energy_checker.
module tb_pendulum_chain_energy_totals_top;
    import pce_pkg::*;

    localparam logic [1:0] MODE_NONE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         CYCLE_CAP  = 3000000;
    localparam int         SETTLE     = 200;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CIDX_W-1:0]    cfg_index = '0;
    logic [CDATA_W-1:0]   cfg_data  = '0;

    int fail_count;
    int totals_waiting;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stalls_started = 0;
    int stall_left = 0;
    int cycle_count = 0;

    always #5 aclk = ~aclk;

    pendulum_chain_energy_totals_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pce_energy_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .totals_waiting(totals_waiting)
    );

    // Result side: random stalls, or a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stalls_started != stall_requests) begin
            stalls_started <= stalls_started + 1;
            stall_left     <= 3000;
            m_tready       <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_pendulum(int an, int bf, int ms, int ln,
                                                      int gr, int cp, int ph);
        return {16'(ph), 16'(cp), 16'(gr), 16'(ln), 16'(ms), 16'(bf), 16'(an)};
    endfunction

    // Mostly physical magnitudes so sums stay in range; some fully random beats.
    function automatic logic [IN_W-1:0] random_pendulum(bit tame);
        int an;
        if (!tame) return {$urandom, $urandom, $urandom, 16'($urandom)};
        an = $urandom_range(8192) - 4096;
        return pack_pendulum(an, an + $urandom_range(512) - 256, $urandom_range(1024),
                             $urandom_range(1024), -$urandom_range(3000),
                             -$urandom_range(600) + (($urandom_range(9) == 0) ? 700 : 0),
                             $urandom_range(2048) - 1024);
    endfunction

    task automatic send_pendulum(logic [IN_W-1:0] d, logic last_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= d;
        s_tlast  <= last_flag;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every chain has reported, then lets a chain in flight settle.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (totals_waiting != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_registers(logic [31:0] inv, logic [1:0] mode, logic ring);
        drain_block();
        write_register(CFG_INV_DT, inv);
        write_register(CFG_MODE, 32'(mode));
        write_register(CFG_RING, 32'(ring));
    endtask

    task automatic random_chains(int beats);
        int sent;
        int len;
        sent = 0;
        while (sent < beats) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 7) : $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                send_pendulum(random_pendulum($urandom_range(3) != 0), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed chains (reset registers, then spare and harmonic mode): lone pendulums at
        // the field extremes, positive coefficients, and short chains with phase offsets.
        send_pendulum(pack_pendulum(0, 0, 0, 0, 0, 0, 0), 1'b1);
        send_pendulum(pack_pendulum(32767, -32768, 65535, 65535, 32767, 32767, -32768), 1'b1);
        send_pendulum(pack_pendulum(-32768, 32767, 65535, 65535, -32768, -32768, 32767), 1'b1);
        send_pendulum(pack_pendulum(1000, 900, 256, 256, -2500, -128, 0), 1'b0);
        send_pendulum(pack_pendulum(-1500, -1400, 512, 128, -2500, -300, 200), 1'b0);
        send_pendulum(pack_pendulum(3000, 3100, 300, 700, -2500, -50, -400), 1'b1);
        send_pendulum(pack_pendulum(12868, 12000, 256, 256, 100, 40, 6434), 1'b0);
        send_pendulum(pack_pendulum(25736, -25736, 256, 256, -256, -256, 0), 1'b1);
        set_registers(32'd65536, MODE_SPARE, 1'b1);
        send_pendulum(pack_pendulum(2000, 1000, 256, 256, -2500, -256, 100), 1'b0);
        send_pendulum(pack_pendulum(-2000, 0, 256, 256, -2500, -256, 100), 1'b1);
        set_registers(32'd65536, MODE_HARM, 1'b0);
        send_pendulum(pack_pendulum(4096, 0, 256, 256, -2500, -256, 0), 1'b0);
        send_pendulum(pack_pendulum(-4096, 0, 256, 256, 2500, 256, 0), 1'b1);
        send_pendulum(pack_pendulum(32767, 0, 65535, 65535, -32768, -32768, 32767), 1'b1);

        send_idle_pct = 17;
        recv_idle_pct = 70;
        set_registers(32'd0, MODE_GRAV, 1'b0);
        random_chains(130);
        set_registers(32'hFFFF_FFFF, MODE_HARM, 1'b1);
        random_chains(130);

        send_idle_pct = 70;
        recv_idle_pct = 17;
        set_registers(32'($urandom), MODE_NONE, 1'b1);
        random_chains(130);
        set_registers(32'($urandom_range(262144)), MODE_SPARE, 1'b0);
        random_chains(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_registers(32'($urandom_range(131072)), MODE_GRAV, 1'b1);
        stall_requests = 1;
        random_chains(150);
        set_registers(32'd65536, MODE_HARM, 1'b1);
        random_chains(65);

        drain_block();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/pce_pkg.sv
rtl/core/pce_mul.sv
rtl/core/pce_ctrl.sv
rtl/core/pce_dp.sv
rtl/core/pendulum_chain_energy_totals_top.sv
tb/pce_energy_checker.sv
tb/tb_pendulum_chain_energy_totals_top.sv
